// ===== rtl/rede_pkg.sv =====
package rede_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  // register values after reset
  localparam logic [47:0]        TARGET_ADDR_RST  = 48'd0;
  localparam logic signed [14:0] TX_POWER_RST     = -15'sd6102;
  localparam logic [13:0]        PATH_LOSS_RST    = 14'd2187;
  localparam logic [7:0]         EMA_DIVISOR_RST  = 8'd30;
  localparam logic [7:0]         SEED_SAMPLES_RST = 8'd11;

  // log2(10) and the 2^f cubic, all Q20
  localparam logic [21:0] LOG2_10_Q20 = 22'd3483294;
  localparam logic [21:0] EXP_ONE     = 22'd1048576;
  localparam logic [21:0] EXP_C1      = 22'd729878;
  localparam logic [21:0] EXP_C2      = 22'd235399;
  localparam logic [21:0] EXP_C3      = 22'd83299;

  localparam logic [19:0] MM_MAX      = 20'hFFFFF;
  localparam int          K_SAT_MIN   = 11;
  localparam int          K_ZERO_MAX  = -13;

  typedef enum logic [2:0] {
    CFG_TARGET_ADDR  = 3'd0,
    CFG_TX_POWER     = 3'd1,
    CFG_PATH_LOSS    = 3'd2,
    CFG_EMA_DIVISOR  = 3'd3,
    CFG_SEED_SAMPLES = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0]        target_addr;
    logic signed [14:0] tx_power_centi_db;
    logic [13:0]        path_loss_centi;
    logic [7:0]         ema_divisor;
    logic [7:0]         seed_samples;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] smoothed_rssi;
    logic [19:0]        distance_mm;
    logic               distance_saturated;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SEED_GO,
    ST_SEED_WAIT,
    ST_EMA_A_GO,
    ST_EMA_A_WAIT,
    ST_EMA_R_GO,
    ST_EMA_R_WAIT,
    ST_EMA_SUM,
    ST_DIST_NUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIST_SHIFT,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_HORNER,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/rede_front.sv =====
module rede_front import rede_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] device_addr,
  input  logic [7:0]  rssi_sample,
  output logic        push,
  output logic [7:0]  push_data,
  input  logic        push_ready
);

  logic       hold_valid;
  logic       hold_hit;
  logic [7:0] hold_rssi;
  logic       drain;
  logic       accept;

  // a non-target item leaves the holding stage at once and is dropped
  assign drain     = hold_valid && (!hold_hit || push_ready);
  assign in_stall  = hold_valid && !drain;
  assign accept    = in_valid && !in_stall;
  assign push      = hold_valid && hold_hit;
  assign push_data = hold_rssi;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_hit  <= (device_addr == cfg.target_addr);
      hold_rssi <= rssi_sample;
    end
  end

endmodule

// ===== rtl/rede_fifo.sv =====
module rede_fifo import rede_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       push_ready,
  input  logic       pop,
  output logic [7:0] pop_data,
  output logic       pop_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push_ok;
  logic             pop_ok;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_ok    = push && push_ready;
  assign pop_ok     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/rede_div.sv =====
module rede_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic             rem_nz
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_hold;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_next;

  // restoring division, one quotient bit a cycle; quo shifts the dividend out
  // at the top and takes quotient bits in at the bottom
  assign trial    = {rem, quo[NUM_W-1]};
  assign fits     = (trial >= {1'b0, den_hold});
  assign diff     = trial - {1'b0, den_hold};
  assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign rem_nz   = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // hold the divisor for the whole pass
  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= num;
      rem      <= '0;
      den_hold <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

// ===== rtl/rede_back.sv =====
module rede_back import rede_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       pop_valid,
  input  logic [7:0] pop_data,
  output logic       pop,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_taken
);

  localparam int AW    = FRAC_BITS + 8;
  localparam int NW    = FRAC_BITS + 16;
  localparam int HW    = FRAC_BITS + 23;
  localparam int PW    = FRAC_BITS + 39;
  localparam int XW    = 35;
  localparam int YW    = 36;
  localparam int KW    = YW - 16;
  localparam int DW    = (FRAC_BITS + 15 > XW - 1) ? FRAC_BITS + 15 : XW - 1;
  localparam int DEN_W = 14;

  localparam logic signed [AW-1:0] A_HI = {8'h7F, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] A_LO = {8'h80, {FRAC_BITS{1'b0}}};
  localparam logic signed [KW-1:0] K_SAT  = KW'(K_SAT_MIN);
  localparam logic signed [KW-1:0] K_ZERO = KW'(K_ZERO_MAX);
  localparam logic signed [22:0]   LOG2_10_S = {1'b0, LOG2_10_Q20};

  back_state_t state;
  back_state_t state_next;

  logic [7:0]         count;
  logic signed [15:0] sum;
  logic               seeded;
  logic signed [AW-1:0] avg;
  logic [1:0]         step;

  logic signed [7:0]    rssi;
  logic signed [AW-1:0] ad;
  logic signed [AW-1:0] rd;
  logic signed [NW-1:0] numr;
  logic [37:0]          pl;
  logic signed [HW-1:0] ph;
  logic signed [XW-1:0] xr;
  logic signed [KW-1:0] kr;
  logic [15:0]          fr;
  logic [21:0]          t;
  logic [31:0]          v;
  logic [19:0]          mm;
  logic                 sat;

  logic             div_start;
  logic [DW-1:0]    div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy;
  logic             div_done;
  logic [DW-1:0]    div_quo;
  logic             div_rem_nz;

  logic [7:0]           need;
  logic [7:0]           divisor;
  logic [DEN_W-1:0]     path_loss;
  logic [7:0]           cnt_inc;
  logic signed [15:0]   sum_inc;
  logic [15:0]          sum_mag;
  logic [AW-1:0]        avg_mag;
  logic [7:0]           rssi_mag;
  logic [AW-1:0]        quo_a;
  logic signed [AW+1:0] ema_sum;
  logic signed [AW-1:0] ema_sat;
  logic signed [NW-1:0] tx_ext;
  logic signed [NW-1:0] a_ext;
  logic signed [NW-1:0] num_calc;
  logic [37:0]          pl_mul;
  logic signed [HW-1:0] ph_mul;
  logic signed [PW-1:0] ph_ext;
  logic signed [PW-1:0] pl_ext;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic [XW-1:0]        x_mag;
  logic [YW-1:0]        q_ext;
  logic signed [YW-1:0] y_val;
  logic [37:0]          horner_mul;
  logic [21:0]          horner_c;
  logic [31:0]          v_mul;
  logic [KW-1:0]        sh_full;
  logic [5:0]           sh;
  logic [32:0]          rnd;
  logic [32:0]          r;
  logic signed [FRAC_BITS+23:0] avg_wide;
  logic signed [FRAC_BITS+23:0] avg_q16;

  rede_div #(
    .NUM_W (DW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  // zero in any of these registers acts as one
  assign need      = (cfg.seed_samples == '0) ? 8'd1 : cfg.seed_samples;
  assign divisor   = (cfg.ema_divisor == '0) ? 8'd1 : cfg.ema_divisor;
  assign path_loss = (cfg.path_loss_centi == '0) ? DEN_W'(1) : cfg.path_loss_centi;

  assign cnt_inc  = count + 1'b1;
  assign sum_inc  = sum + 16'(signed'(pop_data));
  assign sum_mag  = sum[15] ? -sum : sum;
  assign avg_mag  = avg[AW-1] ? -avg : avg;
  assign rssi_mag = rssi[7] ? -rssi : rssi;
  assign quo_a    = div_quo[AW-1:0];

  always_comb begin
    ema_sum = (AW+2)'(avg) - (AW+2)'(ad) + (AW+2)'(rd);
    if (ema_sum < (AW+2)'(A_LO)) begin
      ema_sat = A_LO;
    end else if (ema_sum > (AW+2)'(A_HI)) begin
      ema_sat = A_HI;
    end else begin
      ema_sat = ema_sum[AW-1:0];
    end
  end

  // num = tx * 2^F - 100 * a, then its product with log2(10) in two halves
  always_comb begin
    tx_ext   = NW'($signed(cfg.tx_power_centi_db)) <<< FRAC_BITS;
    a_ext    = NW'(avg);
    num_calc = tx_ext - a_ext * NW'(100);
    pl_mul   = numr[15:0] * LOG2_10_Q20;
    ph_mul   = $signed(numr[NW-1:16]) * LOG2_10_S;
    ph_ext   = PW'(ph);
    pl_ext   = PW'(pl);
    prod     = (ph_ext <<< 16) + pl_ext;
    prod_sh  = prod >>> (FRAC_BITS + 4);
    x_mag    = xr[XW-1] ? -xr : xr;
  end

  // floor division: a negative dividend with a remainder rounds one further down
  always_comb begin
    q_ext = YW'(div_quo[XW-2:0]);
    y_val = xr[XW-1] ? -(q_ext + YW'(div_rem_nz)) : q_ext;
  end

  always_comb begin
    horner_mul = t * fr;
    unique case (step)
      2'd0:    horner_c = EXP_C2;
      2'd1:    horner_c = EXP_C1;
      default: horner_c = EXP_ONE;
    endcase
    v_mul = t * 10'd1000;
  end

  always_comb begin
    sh_full = KW'(20) - kr;
    sh      = sh_full[5:0];
    rnd     = {1'b0, v} + (33'd1 << (sh - 6'd1));
    r       = rnd >> sh;
  end

  always_comb begin
    avg_wide = (FRAC_BITS+24)'(avg) <<< 16;
    avg_q16  = avg_wide >>> FRAC_BITS;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          if (seeded) begin
            state_next = ST_EMA_A_GO;
          end else if (cnt_inc >= need) begin
            state_next = ST_SEED_GO;
          end
        end
      end
      ST_SEED_GO:    state_next = ST_SEED_WAIT;
      ST_SEED_WAIT:  if (div_done) state_next = ST_EMA_A_GO;
      ST_EMA_A_GO:   state_next = ST_EMA_A_WAIT;
      ST_EMA_A_WAIT: if (div_done) state_next = ST_EMA_R_GO;
      ST_EMA_R_GO:   state_next = ST_EMA_R_WAIT;
      ST_EMA_R_WAIT: if (div_done) state_next = ST_EMA_SUM;
      ST_EMA_SUM:    state_next = ST_DIST_NUM;
      ST_DIST_NUM:   state_next = ST_MUL_LO;
      ST_MUL_LO:     state_next = ST_MUL_HI;
      ST_MUL_HI:     state_next = ST_DIST_SHIFT;
      ST_DIST_SHIFT: state_next = ST_DIST_GO;
      ST_DIST_GO:    state_next = ST_DIST_WAIT;
      ST_DIST_WAIT:  if (div_done) state_next = ST_HORNER;
      ST_HORNER:     if (step == 2'd2) state_next = ST_SCALE;
      ST_SCALE:      state_next = ST_ROUND;
      ST_ROUND:      state_next = ST_EMIT;
      ST_EMIT:       if (res_taken) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == ST_IDLE) && pop_valid;
    res_valid = (state == ST_EMIT);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DEN_W'(divisor);
    unique case (state)
      ST_SEED_GO: begin
        div_start = 1'b1;
        div_num   = DW'(sum_mag[14:0]) << FRAC_BITS;
        div_den   = DEN_W'(count);
      end
      ST_EMA_A_GO: begin
        div_start = 1'b1;
        div_num   = DW'(avg_mag);
      end
      ST_EMA_R_GO: begin
        div_start = 1'b1;
        div_num   = DW'(rssi_mag) << FRAC_BITS;
      end
      ST_DIST_GO: begin
        div_start = 1'b1;
        div_num   = DW'(x_mag[XW-2:0]);
        div_den   = path_loss;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
    res.smoothed_rssi      = avg_q16[23:0];
    res.distance_mm        = mm;
    res.distance_saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      sum    <= '0;
      seeded <= 1'b0;
      avg    <= '0;
      step   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && pop_valid && !seeded) begin
        count <= cnt_inc;
        sum   <= sum_inc;
      end
      if (state == ST_SEED_WAIT && div_done) begin
        avg    <= sum[15] ? -quo_a : quo_a;
        seeded <= 1'b1;
      end
      if (state == ST_EMA_SUM) begin
        avg <= ema_sat;
      end
      if (state == ST_DIST_WAIT) begin
        step <= '0;
      end else if (state == ST_HORNER) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      rssi <= pop_data;
    end
    if (state == ST_EMA_A_WAIT && div_done) begin
      ad <= avg[AW-1] ? -quo_a : quo_a;
    end
    if (state == ST_EMA_R_WAIT && div_done) begin
      rd <= rssi[7] ? -quo_a : quo_a;
    end
    if (state == ST_DIST_NUM) begin
      numr <= num_calc;
    end
    if (state == ST_MUL_LO) begin
      pl <= pl_mul;
    end
    if (state == ST_MUL_HI) begin
      ph <= ph_mul;
    end
    if (state == ST_DIST_SHIFT) begin
      xr <= prod_sh[XW-1:0];
    end
    if (state == ST_DIST_WAIT && div_done) begin
      kr <= y_val[YW-1:16];
      fr <= y_val[15:0];
      t  <= EXP_C3;
    end
    if (state == ST_HORNER) begin
      t <= horner_c + horner_mul[37:16];
    end
    if (state == ST_SCALE) begin
      v <= v_mul;
    end
    if (state == ST_ROUND) begin
      priority if (kr >= K_SAT) begin
        mm  <= MM_MAX;
        sat <= 1'b1;
      end else if (kr <= K_ZERO) begin
        mm  <= '0;
        sat <= 1'b0;
      end else if (r > 33'(MM_MAX)) begin
        mm  <= MM_MAX;
        sat <= 1'b1;
      end else begin
        mm  <= r[19:0];
        sat <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    (avg >= A_LO) && (avg <= A_HI))
    else $error("moving average outside its saturation range");

  a_seeded_sticky: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("filter lost its seed");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    seeded |=> $stable(count))
    else $error("sample count moved after seeding");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

// ===== rtl/rssi_ema_distance_estimator_core.sv =====
// RSSI moving-average and distance estimator. Observations arrive as
// (device_addr, rssi_sample) transfers; only those matching target_addr are
// queued, the rest are dropped in the front stage. The first seed_samples
// target samples seed the average with their mean; from then on each target
// sample updates the Q8.FRAC_BITS average and yields one result carrying the
// smoothed RSSI (Q8.16) and a log-distance path-loss estimate in millimetres,
// saturated with a flag at 1048575. A result-producing sample occupies the
// back end from leaving the queue to handing over its result, which can wait
// on the output register; three passes through the shared restoring divider
// (one quotient bit a cycle) dominate that time. The sample that seeds the
// filter makes a fourth divider pass; samples before it only add to the seed
// sum. A two-entry queue lets the front keep accepting during that time.
// Configuration writes are always taken and must only be issued while no
// target sample is in flight.
module rssi_ema_distance_estimator_core import rede_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [47:0]        device_addr,
  input  logic signed [7:0]  rssi_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] smoothed_rssi,
  output logic [19:0]        distance_mm,
  output logic               distance_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  cfg_t       cfg;
  logic       push;
  logic [7:0] push_data;
  logic       push_ready;
  logic       pop;
  logic [7:0] pop_data;
  logic       pop_valid;
  logic       res_valid;
  res_t       res;
  logic       res_taken;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_addr       <= TARGET_ADDR_RST;
      cfg.tx_power_centi_db <= TX_POWER_RST;
      cfg.path_loss_centi   <= PATH_LOSS_RST;
      cfg.ema_divisor       <= EMA_DIVISOR_RST;
      cfg.seed_samples      <= SEED_SAMPLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET_ADDR:  cfg.target_addr       <= cfg_data;
        CFG_TX_POWER:     cfg.tx_power_centi_db <= cfg_data[14:0];
        CFG_PATH_LOSS:    cfg.path_loss_centi   <= cfg_data[13:0];
        CFG_EMA_DIVISOR:  cfg.ema_divisor       <= cfg_data[7:0];
        CFG_SEED_SAMPLES: cfg.seed_samples      <= cfg_data[7:0];
        default:          cfg.seed_samples      <= cfg.seed_samples;
      endcase
    end
  end

  rede_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .device_addr (device_addr),
    .rssi_sample (rssi_sample),
    .push        (push),
    .push_data   (push_data),
    .push_ready  (push_ready)
  );

  rede_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  rede_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // output register: load when empty or being drained this cycle
  assign res_taken = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      smoothed_rssi      <= res.smoothed_rssi;
      distance_mm        <= res.distance_mm;
      distance_saturated <= res.distance_saturated;
    end
  end

endmodule

// ===== sim/rssi_estimate_checker.sv =====
module rssi_estimate_checker import rede_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [47:0]        device_addr,
  input  logic signed [7:0]  rssi_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] smoothed_rssi,
  input  logic [19:0]        distance_mm,
  input  logic               distance_saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  output int                 n_wait,
  output int                 n_checked,
  output int                 errors
);

  localparam int     FRAC     = FRAC_BITS_DEF;
  localparam longint ONE      = longint'(1) << FRAC;
  localparam longint LOG2_TEN = 3483294;
  localparam longint POLY_A1  = 729878;
  localparam longint POLY_A2  = 235399;
  localparam longint POLY_A3  = 83299;
  localparam longint unsigned MM_CAP = 1048575;

  // register copies
  logic [47:0]        follow_addr;
  logic signed [14:0] tx_cdb;
  logic [13:0]        loss_cdb;
  logic [7:0]         ema_div;
  logic [7:0]         seed_need;

  // filter state
  logic [7:0] seen_cnt;
  int         seed_total;
  longint     avg_q;
  bit         primed;

  res_t predicted_readings[$];

  function automatic longint floor_quot(input longint num, input longint den);
    if (num >= 0)
      return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint ema_next(input longint a, input longint r, input longint dv);
    longint lo;
    longint hi;
    lo = -128 * ONE;
    hi = 127 * ONE;
    a = a - a / dv + (r * ONE) / dv;
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    return a;
  endfunction

  function automatic res_t reading_of(input longint a);
    res_t   rd;
    longint tx, n, num, y, k, f, t, p, sh, q16;
    longint unsigned v, mm;
    tx = tx_cdb;
    n  = loss_cdb;
    if (n == 0) n = 1;
    if (FRAC >= 16)
      q16 = floor_quot(a, longint'(1) << (FRAC - 16));
    else
      q16 = a * (longint'(1) << (16 - FRAC));
    rd.smoothed_rssi      = q16[23:0];
    rd.distance_mm        = '0;
    rd.distance_saturated = 1'b0;
    // exponent of two in Q16, then split into whole and fraction
    num = tx * ONE - 100 * a;
    y   = floor_quot(num * LOG2_TEN, n * (longint'(1) << (FRAC + 4)));
    k   = floor_quot(y, 65536);
    f   = y - k * 65536;
    if (k >= 11) begin
      rd.distance_mm        = '1;
      rd.distance_saturated = 1'b1;
      return rd;
    end
    t  = POLY_A3;
    t  = POLY_A2 + ((t * f) >>> 16);
    t  = POLY_A1 + ((t * f) >>> 16);
    p  = (longint'(1) << 20) + ((t * f) >>> 16);
    sh = 20 - k;
    if (sh < 63) begin
      v  = 1000 * p;
      mm = (v + (64'd1 << (sh - 1))) >> sh;
      if (mm > MM_CAP) begin
        rd.distance_mm        = '1;
        rd.distance_saturated = 1'b1;
      end else begin
        rd.distance_mm = mm[19:0];
      end
    end
    return rd;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_reading();
    res_t want;
    if (predicted_readings.size() == 0) begin
      report($sformatf("estimate with none pending: rssi %0d mm %0d sat %0b",
                       smoothed_rssi, distance_mm, distance_saturated));
      return;
    end
    want = predicted_readings.pop_front();
    n_checked++;
    if (smoothed_rssi !== want.smoothed_rssi)
      report($sformatf("smoothed_rssi %0d, predicted %0d",
                       smoothed_rssi, $signed(want.smoothed_rssi)));
    if (distance_mm !== want.distance_mm)
      report($sformatf("distance_mm %0d, predicted %0d", distance_mm, want.distance_mm));
    if (distance_saturated !== want.distance_saturated)
      report($sformatf("distance_saturated %0b, predicted %0b",
                       distance_saturated, want.distance_saturated));
  endtask

  task automatic apply_write();
    case (cfg_index)
      CFG_TARGET_ADDR:  follow_addr = cfg_data;
      CFG_TX_POWER:     tx_cdb      = cfg_data[14:0];
      CFG_PATH_LOSS:    loss_cdb    = cfg_data[13:0];
      CFG_EMA_DIVISOR:  ema_div     = cfg_data[7:0];
      CFG_SEED_SAMPLES: seed_need   = cfg_data[7:0];
      default: ;
    endcase
  endtask

  task automatic track_observation();
    longint r;
    longint dv;
    int     need;
    if (device_addr != follow_addr)
      return;
    r  = rssi_sample;
    dv = ema_div;
    if (dv == 0) dv = 1;
    if (!primed) begin
      need       = (seed_need == 0) ? 1 : int'(seed_need);
      seen_cnt   = seen_cnt + 8'd1;
      seed_total = seed_total + int'(r);
      // a count already past a lowered seed target primes at once
      if (int'(seen_cnt) < need)
        return;
      avg_q  = (longint'(seed_total) * ONE) / longint'(seen_cnt);
      primed = 1'b1;
    end
    avg_q = ema_next(avg_q, r, dv);
    predicted_readings.insert(predicted_readings.size(), reading_of(avg_q));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      follow_addr = TARGET_ADDR_RST;
      tx_cdb      = TX_POWER_RST;
      loss_cdb    = PATH_LOSS_RST;
      ema_div     = EMA_DIVISOR_RST;
      seed_need   = SEED_SAMPLES_RST;
      seen_cnt    = '0;
      seed_total  = 0;
      avg_q       = 0;
      primed      = 1'b0;
      n_checked   = 0;
      errors      = 0;
      predicted_readings.delete();
    end else begin
      if (out_valid && !out_stall) check_reading();
      if (cfg_valid && cfg_ready) apply_write();
      if (in_valid && !in_stall) track_observation();
    end
    n_wait <= predicted_readings.size();
  end

endmodule

// ===== sim/tb_rssi_ema_distance_estimator_core.sv =====
module tb_rssi_ema_distance_estimator_core;
  import rede_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYC  = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_HITS  = 126;

  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [47:0]        device_addr = '0;
  logic signed [7:0]  rssi_sample = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [23:0] smoothed_rssi;
  logic [19:0]        distance_mm;
  logic               distance_saturated;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index   = '0;
  logic [47:0]        cfg_data    = '0;

  int n_wait, n_checked, errors;
  bit calm = 1'b0;
  int stall_left = 0;
  int rx_draw;
  int quiet = 0;
  int n_sent = 0;
  int n_target = 0;
  int n_phase = 0;
  logic [47:0] target = '0;

  rssi_ema_distance_estimator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .device_addr(device_addr), .rssi_sample(rssi_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .smoothed_rssi(smoothed_rssi), .distance_mm(distance_mm),
    .distance_saturated(distance_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rssi_estimate_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .device_addr(device_addr), .rssi_sample(rssi_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .smoothed_rssi(smoothed_rssi), .distance_mm(distance_mm),
    .distance_saturated(distance_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .n_wait(n_wait), .n_checked(n_checked), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: after each transfer hold stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      rx_draw     = calm ? 0 : int'($urandom_range(0, 19));
      stall_left <= rx_draw;
      out_stall  <= (rx_draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [47:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  task automatic send_obs(input logic [47:0] a, input logic signed [7:0] r);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, 19));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    device_addr <= a;
    rssi_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (a == target) n_target++;
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [47:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [47:0] tgt, input int tx, input int loss,
                           input int div, input int seed);
    target = tgt;
    cfg_write(CFG_TARGET_ADDR, tgt);
    cfg_write(CFG_TX_POWER, 48'(tx));
    cfg_write(CFG_PATH_LOSS, 48'(loss));
    cfg_write(CFG_EMA_DIVISOR, 48'(div));
    cfg_write(CFG_SEED_SAMPLES, 48'(seed));
    cfg_valid <= 1'b0;
    n_phase++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_wait != 0);
  endtask

  // samples that give no estimate may still be in flight: let them finish
  task automatic settle();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int hits;
    int kind;
    int tx_sel;
    int loss_sel;
    int div_sel;
    int centre;
    logic [47:0] a;
    logic signed [7:0] r;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a seed count of 255 keeps the filter unprimed for the first samples
    configure(48'hFFFF_FFFF_FFFF, -12800, 10000, 255, 255);
    send_obs(48'h0, 8'sd127);
    send_obs(48'hFFFF_FFFF_FFFE, 8'sd5);
    send_obs(target, -8'sd128);
    send_obs(target, 8'sd127);
    send_obs(target, 8'sd0);
    send_obs(target, -8'sd1);
    send_obs(target, -8'sd60);
    settle();

    // zero seed count, now below the count reached: next sample primes
    cfg_write(CFG_SEED_SAMPLES, 48'd0);
    cfg_valid <= 1'b0;
    send_obs(target, -8'sd70);
    send_obs(target, 8'sd127);
    send_obs(target, -8'sd128);
    settle();

    // zero divisor and zero path loss with the strongest reference level
    configure(48'h0, 0, 0, 0, 1);
    send_obs(target, -8'sd128);
    send_obs(target, 8'sd127);
    send_obs(target, 8'sd127);
    send_obs(target, -8'sd128);
    settle();

    configure(rand_addr(), -6102, 100, 1, 255);
    send_obs(target, -8'sd61);
    send_obs(target, -8'sd40);
    send_obs(target, -8'sd90);
    send_obs(target ^ 48'h8000_0000_0000, -8'sd20);
    send_obs(target, -8'sd128);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0)
        tx_sel = $urandom_range(0, 1) ? 0 : -12800;
      else
        tx_sel = -int'($urandom_range(0, 12800));
      case ($urandom_range(0, 5))
        0:       loss_sel = 0;
        1:       loss_sel = 100;
        2:       loss_sel = 10000;
        default: loss_sel = $urandom_range(100, 10000);
      endcase
      case ($urandom_range(0, 3))
        0:       div_sel = $urandom_range(0, 4);
        1:       div_sel = 255;
        default: div_sel = $urandom_range(1, 255);
      endcase
      configure(rand_addr(), tx_sel, loss_sel, div_sel, $urandom_range(0, 255));
      calm = ($urandom_range(0, 3) == 0);
      hits = 0;
      while (hits < PHASE_HITS) begin
        kind = $urandom_range(0, 9);
        if (kind == 0)
          a = rand_addr();
        else if (kind == 1)
          a = target ^ (48'h1 << $urandom_range(0, 47));
        else
          a = target;
        if ($urandom_range(0, 1)) begin
          r = 8'($urandom_range(0, 255));
        end else begin
          // keep near the reference level so distances stay in range
          centre = tx_sel / 100 + int'($urandom_range(0, 30)) - 15;
          if (centre < -128) centre = -128;
          if (centre > 127) centre = 127;
          r = 8'(centre);
        end
        if (a == target) hits++;
        send_obs(a, r);
        if ($urandom_range(0, 149) == 0) drain();
      end
      calm = 1'b0;
      settle();
    end

    $display("%0d observations sent, %0d for the followed device, %0d register settings",
             n_sent, n_target, n_phase);
    $display("%0d estimates compared, %0d mismatches", n_checked, errors);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
